### sv/consistent_hash_ring_lookup_assert.svh
// Assertion macros for the consistent hash ring lookup block.
// Used by the port checker; needs a clk and an rst_n in scope.
`ifndef CONSISTENT_HASH_RING_LOOKUP_ASSERT_SVH
`define CONSISTENT_HASH_RING_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHRL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/chrl_pkg.sv
// Shared types, constants and CRC helper for the hash ring lookup.
// No dependencies; compiled before every other file.
`default_nettype none

package chrl_pkg;

  localparam int unsigned MAX_POINTS_DEF = 4096;
  localparam int unsigned MAX_NODES_DEF  = 256;

  localparam int unsigned CNT_W  = 13;
  localparam int unsigned SLOT_W = 12;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned NODE_W = 8;

  localparam logic [HASH_W-1:0] CRC_INIT = 32'hffffffff;
  localparam logic [HASH_W-1:0] CRC_XOR  = 32'hffffffff;

  // Reflected CRC-32 (0xedb88320), one nibble per entry.
  localparam logic [HASH_W-1:0] NIB_TABLE [16] = '{
    32'h00000000, 32'h1db71064, 32'h3b6e20c8, 32'h26d930ac,
    32'h76dc4190, 32'h6b6b51f4, 32'h4db26158, 32'h5005713c,
    32'hedb88320, 32'hf00f9344, 32'hd6d6a3e8, 32'hcb61b38c,
    32'h9b64c2b0, 32'h86d3d2d4, 32'ha00ae278, 32'hbdbdf21c
  };

  typedef enum logic {
    CMD_POINT = 1'b0,
    CMD_KEY   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] point_slot;
    logic [HASH_W-1:0] point_hash;
    logic [NODE_W-1:0] point_node;
    logic [7:0]        key_byte;
    logic              key_last;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [HASH_W-1:0] key_hash;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic fold;        // fold key byte into CRC
    logic close;       // key ends: latch final hash, rearm CRC
    logic wr_pt;       // write one ring point
    logic scan_start;  // rewind scan address
    logic rd_en;       // read slot at scan address, advance
    logic finish;      // launch the result
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hit;      // registered slot qualifies
    logic last_rd;  // scan address is the last slot in use
  } sts_t;

  function automatic logic [HASH_W-1:0] crc_nib(logic [HASH_W-1:0] c, logic [3:0] n);
    return NIB_TABLE[c[3:0] ^ n] ^ (c >> 4);
  endfunction

  function automatic logic [HASH_W-1:0] crc_byte(logic [HASH_W-1:0] c, logic [7:0] b);
    return crc_nib(crc_nib(c, b[3:0]), b[7:4]);
  endfunction

endpackage

`default_nettype wire

### sv/chrl_ctrl.sv
// Control state machine of the hash ring lookup: takes items, runs the scan.
// Depends on chrl_pkg.
`default_nettype none

module chrl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire chrl_pkg::in_item_t in_item,
  input  wire chrl_pkg::sts_t    sts,
  output logic                   busy,
  output chrl_pkg::ctl_t         ctl
);
  import chrl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt      = state_r;
    ctl            = '0;
    ctl.fold       = accept && (in_item.cmd == CMD_KEY);
    ctl.close      = ctl.fold && in_item.key_last;
    ctl.wr_pt      = accept && (in_item.cmd == CMD_POINT);
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.close) begin
          ctl.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          ctl.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          ctl.rd_en = 1'b1;
          if (sts.last_rd) state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last slot's data is in the read register; hit or wrap
        ctl.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/chrl_dpath.sv
// Datapath of the hash ring lookup: CRC, ring memories, scan compare, result.
// Depends on chrl_pkg.
`default_nettype none

module chrl_dpath #(
  parameter int unsigned MAX_POINTS = chrl_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_NODES  = chrl_pkg::MAX_NODES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire chrl_pkg::in_item_t         in_item,
  input  wire chrl_pkg::ctl_t             ctl,
  input  wire logic                       cfg_we,
  input  wire logic [chrl_pkg::CNT_W-1:0] cfg_point_count,
  output chrl_pkg::sts_t                  sts,
  output logic                            out_valid,
  output chrl_pkg::out_item_t             out_item
);
  import chrl_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic [HASH_W-1:0] mem_hash [MAX_POINTS];
  logic [NODE_W-1:0] mem_node [MAX_POINTS];

  logic [HASH_W-1:0] crc_r, crc_nxt;
  logic [HASH_W-1:0] hash_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [AW-1:0]     addr_r;
  logic              rd_vld_r;
  logic              rd_first_r;
  logic [HASH_W-1:0] rd_hash_r;
  logic [NODE_W-1:0] rd_node_r;
  logic [NODE_W-1:0] node0_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [31:0]       cnt_ext, last_ext, slot_ext, node_ext;
  logic [AW-1:0]     last_idx, wr_addr;
  logic              slot_ok;
  logic [NODE_W-1:0] node_st, wrap_node;

  assign crc_nxt = crc_byte(crc_r, in_item.key_byte);

  // Clamp the point count to 1..MAX_POINTS and take the last slot index.
  assign cnt_ext  = 32'(cnt_r);
  assign last_ext = (cnt_ext == 32'd0) ? 32'd0 :
                    (cnt_ext > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) - 32'd1 :
                    cnt_ext - 32'd1;
  assign last_idx = last_ext[AW-1:0];

  assign slot_ext = 32'(in_item.point_slot);
  assign slot_ok  = (slot_ext < 32'(MAX_POINTS));
  assign wr_addr  = slot_ext[AW-1:0];
  assign node_ext = 32'(in_item.point_node);
  assign node_st  = (node_ext >= 32'(MAX_NODES)) ? NODE_W'(MAX_NODES - 1) : in_item.point_node;

  assign sts.hit     = rd_vld_r && (rd_hash_r >= hash_r);
  assign sts.last_rd = (addr_r == last_idx);

  // Slot 0's node, still in the read register when only one slot is in use.
  assign wrap_node = rd_first_r ? rd_node_r : node0_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_pt && slot_ok) begin
      mem_hash[wr_addr] <= in_item.point_hash;
      mem_node[wr_addr] <= node_st;
    end
    if (ctl.rd_en) begin
      rd_hash_r <= mem_hash[addr_r];
      rd_node_r <= mem_node[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      cnt_r       <= CNT_W'(1);
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.close) begin
        crc_r <= CRC_INIT;
      end else if (ctl.fold) begin
        crc_r <= crc_nxt;
      end
      if (cfg_we) cnt_r <= cfg_point_count;
      rd_vld_r    <= ctl.rd_en;
      out_valid_r <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.close) hash_r <= crc_nxt ^ CRC_XOR;
    if (ctl.scan_start) begin
      addr_r <= '0;
    end else if (ctl.rd_en) begin
      addr_r <= addr_r + AW'(1);
    end
    if (ctl.rd_en) rd_first_r <= (addr_r == '0);
    if (rd_vld_r && rd_first_r) node0_r <= rd_node_r;
    if (ctl.finish) begin
      out_r.node_index <= sts.hit ? rd_node_r : wrap_node;
      out_r.key_hash   <= hash_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

### sv/consistent_hash_ring_lookup.sv
// Top level of the consistent hash ring lookup: controller plus datapath.
// Depends on chrl_pkg, chrl_ctrl and chrl_dpath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | start / busy         | in_item  (cmd, point, key byte, last)
//  result   | out_valid (strobe)   | out_item (node_index, key_hash)
//  config   | cfg_valid/cfg_ready  | cfg_point_count
//
// An item is taken at an edge with start high and busy low. Point writes and
// key bytes that are not the last never raise busy, so key bytes stream at
// one per cycle while no lookup runs (two CRC nibble steps per cycle).
// A last key byte starts a linear scan of the ring memory, one slot per cycle
// through the memory's single read port, until a slot qualifies or the scan
// wraps after the last slot in use. out_valid pulses for one cycle as busy
// drops; the receiver cannot stall. Synchronous active-low reset clears
// control state, rearms the CRC and sets point_count to 1; the ring memory
// is not cleared.
`default_nettype none

module consistent_hash_ring_lookup #(
  parameter int unsigned MAX_POINTS = chrl_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_NODES  = chrl_pkg::MAX_NODES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // item input
  input  wire logic                       start,
  output logic                            busy,
  input  wire chrl_pkg::in_item_t         in_item,
  // results
  output logic                            out_valid,
  output chrl_pkg::out_item_t             out_item,
  // point_count register
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [chrl_pkg::CNT_W-1:0] cfg_point_count
);
  import chrl_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic cfg_we;

  // Take register writes only between lookups.
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  chrl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .sts     (sts),
    .busy    (busy),
    .ctl     (ctl)
  );

  chrl_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_NODES  (MAX_NODES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_item         (in_item),
    .ctl             (ctl),
    .cfg_we          (cfg_we),
    .cfg_point_count (cfg_point_count),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_item        (out_item)
  );

endmodule

`default_nettype wire

### sv/chrl_checker.sv
// Port-level checker for the hash ring lookup, bound to the top level.
// Depends on chrl_pkg and consistent_hash_ring_lookup_assert.svh.
`default_nettype none

`include "consistent_hash_ring_lookup_assert.svh"

module chrl_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire chrl_pkg::in_item_t in_item,
  input wire logic               out_valid,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready
);
  import chrl_pkg::*;

  logic take, take_last;

  assign take      = start && !busy;
  assign take_last = take && (in_item.cmd == CMD_KEY) && in_item.key_last;

  `CHRL_ASSERT_NEXT(a_last_goes_busy, take_last, busy, "last key byte did not start a lookup")
  `CHRL_ASSERT_NEXT(a_no_spurious_out, take && !take_last, !out_valid, "result without last byte")
  `CHRL_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held two cycles")
  `CHRL_ASSERT_SAME(a_done_has_result, $fell(busy) && $past(rst_n), out_valid, "lookup ended without result")
  `CHRL_ASSERT_SAME(a_cfg_when_idle, cfg_valid && cfg_ready, !busy, "register write taken during a lookup")

endmodule

bind consistent_hash_ring_lookup chrl_checker u_chrl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
